// File: rtl/scls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_pkg: shared types and constants of the column level scheduler
// Sizes of the level store and histogram, command codes, sequencer states
// and the operation codes of the shared compare/increment unit.
// ----------------------------------------------------------------------------
package scls_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int NEXT_W      = COL_W + 1;
   localparam int LEVEL_LIMIT = 1024;
   localparam int FIELD_W     = 10;
   localparam int LVL_W       = $clog2(LEVEL_LIMIT);
   localparam int CNT_W       = 11;
   localparam int ALU_W       = 12;
   localparam int LEVEL_TOP   = LEVEL_LIMIT - 1;
   localparam int COUNT_TOP   = (1 << CNT_W) - 1;

   typedef logic signed [ALU_W-1:0] alu_word_type;

   typedef enum logic [1:0] {
      CMD_DEP   = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic {
      ALU_MAX,
      ALU_INC_SAT
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DEP_CMP,
      ST_CLOSE_LVL,
      ST_CLOSE_RD,
      ST_CLOSE_INC,
      ST_BKT_OUT
   } state_type;

endpackage

// File: rtl/sparse_column_level_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_column_level_scheduler: level assignment for sparse triangular columns
// Sequencer around a level store, a per-level histogram and one shared
// compare/increment unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_command, req_dep_index and req_bucket with start; an item is
//   taken at a clock edge where start is high and busy is low.
//   Dependency entry: store read, then max compare; no result.
//   Close: the result strobes on rsp_strobe in the cycle after the
//   sequencer finishes the histogram update. A close past the column
//   capacity returns overflow in the next cycle.
//   Histogram read: the count is read from the histogram, then registered.
//   Command 3 returns nothing and leaves busy low.
//   Each result is flagged by rsp_strobe for exactly one cycle; the
//   receiver cannot stall, so results are never held.
//   The rate is set by the registered reads of the level store and the
//   histogram and the one shared compare/increment unit, used at most once
//   per sequencer step.
//   Reset is synchronous; after it the histogram is swept to zero, one
//   bucket per cycle, while busy stays high. Unwritten level store entries
//   read as unset through the running column count.
// ----------------------------------------------------------------------------
module sparse_column_level_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [scls_pkg::FIELD_W-1:0] req_dep_index,
   input  logic [scls_pkg::FIELD_W-1:0] req_bucket,
   output logic                         rsp_strobe,
   output logic [scls_pkg::FIELD_W-1:0] rsp_column,
   output logic [scls_pkg::FIELD_W-1:0] rsp_level,
   output logic [scls_pkg::FIELD_W-1:0] rsp_peak_level,
   output logic [scls_pkg::CNT_W-1:0]   rsp_count,
   output logic                         rsp_overflow
);
   import scls_pkg::*;

   state_type            state_ff, state_in;
   logic [LVL_W-1:0]     clr_addr_ff, clr_addr_in;
   alu_word_type         running_max_ff, running_max_in;
   logic [NEXT_W-1:0]    next_col_ff, next_col_in;
   logic [LVL_W-1:0]     peak_ff, peak_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 dep_valid_ff, dep_valid_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [FIELD_W-1:0]   rsp_column_ff, rsp_column_in;
   logic [FIELD_W-1:0]   rsp_level_ff, rsp_level_in;
   logic [FIELD_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 accept;
   cmd_type              cmd;

   logic                 store_we;
   logic [COL_W-1:0]     store_waddr, store_raddr;
   logic [LVL_W-1:0]     store_wdata, store_rdata;
   logic                 hist_we;
   logic [LVL_W-1:0]     hist_waddr, hist_raddr;
   logic [CNT_W-1:0]     hist_wdata, hist_rdata;

   alu_op_type           alu_op;
   alu_word_type         alu_a, alu_b, alu_y;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_command);

   scls_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(LVL_W)) u_level_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   scls_ram #(.DEPTH(LEVEL_LIMIT), .WIDTH(CNT_W)) u_level_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   scls_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         running_max_ff <= '1;
         next_col_ff    <= '0;
         peak_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         running_max_ff <= running_max_in;
         next_col_ff    <= next_col_in;
         peak_ff        <= peak_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      dep_valid_ff  <= dep_valid_in;
      rsp_column_ff <= rsp_column_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // sequencer: next state, memory ports and shared unit operands
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      running_max_in = running_max_ff;
      next_col_in    = next_col_ff;
      peak_in        = peak_ff;
      level_in       = level_ff;
      dep_valid_in   = dep_valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_column_in  = rsp_column_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      store_we       = 1'b0;
      store_waddr    = COL_W'(next_col_ff);
      store_wdata    = level_ff;
      store_raddr    = COL_W'(req_dep_index);
      hist_we        = 1'b0;
      hist_waddr     = level_ff;
      hist_wdata     = '0;
      hist_raddr     = LVL_W'(req_bucket);
      alu_op         = ALU_MAX;
      alu_a          = running_max_ff;
      alu_b          = running_max_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the histogram to zero
            hist_we     = 1'b1;
            hist_waddr  = clr_addr_ff;
            clr_addr_in = clr_addr_ff + LVL_W'(1);
            if (clr_addr_ff == LVL_W'(LEVEL_LIMIT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_DEP: begin
                     // a column not yet closed reads unset
                     dep_valid_in = (32'(req_dep_index) < 32'(next_col_ff));
                     state_in     = ST_DEP_CMP;
                  end
                  CMD_CLOSE: begin
                     if (32'(next_col_ff) >= MAX_COLUMNS) begin
                        // out of columns: flag and drop
                        running_max_in = '1;
                        rsp_strobe_in  = 1'b1;
                        rsp_column_in  = '0;
                        rsp_level_in   = '0;
                        rsp_max_in     = FIELD_W'(peak_ff);
                        rsp_count_in   = '0;
                        rsp_ovf_in     = 1'b1;
                     end else begin
                        state_in = ST_CLOSE_LVL;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_BKT_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DEP_CMP: begin
            // fold the stored level into the running maximum
            alu_op         = ALU_MAX;
            alu_a          = dep_valid_ff ? alu_word_type'(ALU_W'(store_rdata)) : '1;
            alu_b          = running_max_ff;
            running_max_in = alu_y;
            state_in       = ST_IDLE;
         end
         ST_CLOSE_LVL: begin
            // level is running maximum plus one, saturated
            alu_op   = ALU_INC_SAT;
            alu_a    = running_max_ff;
            alu_b    = alu_word_type'(LEVEL_TOP);
            level_in = LVL_W'(alu_y);
            state_in = ST_CLOSE_RD;
         end
         ST_CLOSE_RD: begin
            // store the level, fetch its bucket, update the peak
            store_we   = 1'b1;
            hist_raddr = level_ff;
            alu_op     = ALU_MAX;
            alu_a      = alu_word_type'(ALU_W'(level_ff));
            alu_b      = alu_word_type'(ALU_W'(peak_ff));
            peak_in    = LVL_W'(alu_y);
            state_in   = ST_CLOSE_INC;
         end
         ST_CLOSE_INC: begin
            // count the column and report it
            alu_op         = ALU_INC_SAT;
            alu_a          = alu_word_type'(ALU_W'(hist_rdata));
            alu_b          = alu_word_type'(COUNT_TOP);
            hist_we        = 1'b1;
            hist_wdata     = CNT_W'(alu_y);
            rsp_strobe_in  = 1'b1;
            rsp_column_in  = FIELD_W'(next_col_ff);
            rsp_level_in   = FIELD_W'(level_ff);
            rsp_max_in     = FIELD_W'(peak_ff);
            rsp_count_in   = '0;
            rsp_ovf_in     = 1'b0;
            next_col_in    = next_col_ff + NEXT_W'(1);
            running_max_in = '1;
            state_in       = ST_IDLE;
         end
         ST_BKT_OUT: begin
            // report the bucket count
            rsp_strobe_in = 1'b1;
            rsp_column_in = '0;
            rsp_level_in  = '0;
            rsp_max_in    = FIELD_W'(peak_ff);
            rsp_count_in  = hist_rdata;
            rsp_ovf_in    = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_peak_level = rsp_max_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_overflow   = rsp_ovf_ff;

`ifndef SYNTHESIS
   // the column count never passes the capacity
   a_next_col_bound: assert property (@(posedge clock) disable iff (reset)
      32'(next_col_ff) <= MAX_COLUMNS)
      else $error("column count beyond capacity");

   // a finished close leaves the running maximum unset
   a_max_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLOSE_INC |=> running_max_ff == '1)
      else $error("running maximum not cleared after close");

   // an overflow result carries no level and no count
   a_ovf_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ovf_ff |-> rsp_level_ff == '0 && rsp_count_ff == '0)
      else $error("overflow result with payload");

   // a reported level never exceeds the reported peak
   a_level_le_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_level_ff <= rsp_max_ff)
      else $error("level above peak");

   // a close that was counted takes one column
   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLOSE_INC |=> next_col_ff == $past(next_col_ff) + NEXT_W'(1))
      else $error("column count did not advance");
`endif

endmodule

// File: rtl/scls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scls_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/scls_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scls_alu: shared compare/increment unit
// Signed maximum of two words, or increment of a word saturating at a limit.
// ----------------------------------------------------------------------------
module scls_alu (
   input  scls_pkg::alu_op_type   op,
   input  scls_pkg::alu_word_type a,
   input  scls_pkg::alu_word_type b,
   output scls_pkg::alu_word_type y
);
   import scls_pkg::*;

   logic a_ge_b;

   // one signed compare serves both operations
   assign a_ge_b = (a >= b);

   always_comb begin
      case (op)
         ALU_MAX:     y = a_ge_b ? a : b;
         ALU_INC_SAT: y = a_ge_b ? b : a + alu_word_type'(1);
         default:     y = a;
      endcase
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sparse column level scheduler
// Pushes dependency, close, histogram read and no-op commands through the
// start/busy handshake, keeps its own copy of the level store, histogram and
// running maximum, and checks every strobed result in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import scls_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 16;
   localparam int RANDOM_ITEMS = 200;
   localparam int IDLE_PERCENT = 6;
   localparam int PRINT_LIMIT  = 50;

   typedef struct {
      logic [FIELD_W-1:0] column;
      logic [FIELD_W-1:0] level;
      logic [FIELD_W-1:0] peak_level;
      logic [CNT_W-1:0]   count;
      logic               overflow;
   } sched_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = CMD_NONE;
   logic [FIELD_W-1:0] req_dep_index = '0;
   logic [FIELD_W-1:0] req_bucket = '0;
   logic               rsp_strobe;
   logic [FIELD_W-1:0] rsp_column;
   logic [FIELD_W-1:0] rsp_level;
   logic [FIELD_W-1:0] rsp_peak_level;
   logic [CNT_W-1:0]   rsp_count;
   logic               rsp_overflow;

   // bench copy of the scheduler state
   alu_word_type       column_level [MAX_COLUMNS];
   logic [CNT_W-1:0]   level_count [LEVEL_LIMIT];
   alu_word_type       dep_max;
   logic [NEXT_W-1:0]  columns_closed;
   logic [LVL_W-1:0]   peak_seen;

   sched_result_type   result_queue [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 items_sent = 0;
   bit                 idle_on = 1'b0;

   sparse_column_level_scheduler dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_dep_index  (req_dep_index),
      .req_bucket     (req_bucket),
      .rsp_strobe     (rsp_strobe),
      .rsp_column     (rsp_column),
      .rsp_level      (rsp_level),
      .rsp_peak_level (rsp_peak_level),
      .rsp_count      (rsp_count),
      .rsp_overflow   (rsp_overflow)
   );

   always #5 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
                  cycle_count);
      error_count++;
   endtask

   // Update the level state for one accepted transfer and queue its result, if it has one.
   function automatic void schedule_step(cmd_type cmd, logic [FIELD_W-1:0] dep,
                                         logic [FIELD_W-1:0] bkt);
      sched_result_type r;
      alu_word_type     next_level;
      r = '{default: '0};
      case (cmd)
         CMD_DEP: begin
            // unclosed columns hold the unset mark and never raise the max
            if (column_level[dep] > dep_max) dep_max = column_level[dep];
         end
         CMD_CLOSE: begin
            if (columns_closed >= MAX_COLUMNS) begin
               r.overflow = 1'b1;
            end else begin
               next_level = dep_max + alu_word_type'(1);
               if (next_level > LEVEL_TOP) next_level = alu_word_type'(LEVEL_TOP);
               column_level[columns_closed[COL_W-1:0]] = next_level;
               if (level_count[next_level[LVL_W-1:0]] != COUNT_TOP)
                  level_count[next_level[LVL_W-1:0]]++;
               if (next_level[LVL_W-1:0] > peak_seen) peak_seen = next_level[LVL_W-1:0];
               r.column = columns_closed[COL_W-1:0];
               r.level  = next_level[LVL_W-1:0];
               columns_closed++;
            end
            dep_max = '1;
            r.peak_level = peak_seen;
            result_queue.push_back(r);
         end
         CMD_READ: begin
            r.count      = level_count[bkt];
            r.peak_level = peak_seen;
            result_queue.push_back(r);
         end
         default: ;
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] any_field();
      return FIELD_W'($urandom_range(MAX_COLUMNS - 1));
   endfunction

   function automatic logic [FIELD_W-1:0] closed_column();
      if (columns_closed == 0) return any_field();
      return FIELD_W'($urandom_range(columns_closed - 1));
   endfunction

   // Present one item, hold it until taken, then predict.
   task automatic send_item(cmd_type cmd, logic [FIELD_W-1:0] dep,
                            logic [FIELD_W-1:0] bkt);
      int gap;
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_command   <= cmd;
      req_dep_index <= dep;
      req_bucket    <= bkt;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      schedule_step(cmd, dep, bkt);
   endtask

   task automatic send_dep(logic [FIELD_W-1:0] dep);
      send_item(CMD_DEP, dep, any_field());
   endtask

   task automatic send_close();
      send_item(CMD_CLOSE, any_field(), any_field());
   endtask

   task automatic send_read(logic [FIELD_W-1:0] bkt);
      send_item(CMD_READ, any_field(), bkt);
   endtask

   // Compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_strobe) begin
         if (result_queue.size() == 0) begin
            report_mismatch("unexpected result, column", rsp_column, 0);
         end else begin
            want = result_queue.pop_front();
            if (rsp_column !== want.column)
               report_mismatch("column", rsp_column, want.column);
            if (rsp_level !== want.level)
               report_mismatch("level", rsp_level, want.level);
            if (rsp_peak_level !== want.peak_level)
               report_mismatch("peak_level", rsp_peak_level, want.peak_level);
            if (rsp_count !== want.count)
               report_mismatch("count", rsp_count, want.count);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
         end
      end
   end

   // Empty histogram, ignored commands, unclosed and self dependencies,
   // reads in the middle of a column.
   task automatic test_directed_cases();
      idle_on = 1'b0;
      send_read('0);
      send_read(FIELD_W'(LEVEL_TOP));
      send_item(CMD_NONE, '1, '1);
      send_close();
      send_dep(1);
      send_dep(FIELD_W'(MAX_COLUMNS - 1));
      send_close();
      send_dep(0);
      send_close();
      send_dep(2);
      send_dep(0);
      send_dep(1);
      send_close();
      send_dep(3);
      send_item(CMD_NONE, 10'h2AA, 10'h155);
      send_read(2);
      send_dep(4);
      send_close();
      send_read(0);
      send_read(1);
      send_read(3);
      send_read(10'h200);
   endtask

   // Hold the sender until every queued result has come back.
   task automatic test_pause_until_drained();
      send_dep(closed_column());
      send_dep(closed_column());
      send_close();
      send_read(1);
      start <= 1'b0;
      @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      send_read(0);
   endtask

   // Mostly well-formed columns with random dependencies, plus reads and noise.
   task automatic test_random_columns();
      int stop_at;
      int calm_from;
      int calm_to;
      int pick;
      int deps;
      stop_at   = items_sent + RANDOM_ITEMS;
      calm_from = items_sent + 40;
      calm_to   = calm_from + 120;
      while (items_sent < stop_at && columns_closed < MAX_COLUMNS - 200) begin
         // keep a long stretch free of idle cycles
         idle_on = !(items_sent >= calm_from && items_sent < calm_to);
         pick = $urandom_range(99);
         if (pick < 78) begin
            deps = $urandom_range(0, 4);
            repeat (deps) begin
               if ($urandom_range(3) != 0) send_dep(closed_column());
               else send_dep(any_field());
               if ($urandom_range(9) == 0) send_read(FIELD_W'($urandom_range(peak_seen + 1)));
            end
            send_close();
         end else if (pick < 90) begin
            if ($urandom_range(9) < 7) send_read(FIELD_W'($urandom_range(peak_seen + 1)));
            else send_read(any_field());
         end else if (pick < 95) begin
            send_item(CMD_NONE, any_field(), any_field());
         end else begin
            send_dep(any_field());
         end
      end
   endtask

   // Close the remaining columns, chaining some of them, then close past
   // capacity.
   task automatic test_column_capacity();
      idle_on = 1'b1;
      while (columns_closed < MAX_COLUMNS) begin
         if ($urandom_range(15) == 0) send_dep(FIELD_W'(columns_closed - 1));
         if ($urandom_range(63) == 0) send_dep(closed_column());
         if ($urandom_range(63) == 0) send_read(any_field());
         send_close();
      end
      send_dep(FIELD_W'(MAX_COLUMNS - 1));
      send_close();
      send_close();
      send_dep(any_field());
      send_item(CMD_NONE, any_field(), any_field());
      send_close();
      send_read(peak_seen);
      send_read('0);
      send_read(FIELD_W'(LEVEL_TOP));
      repeat (8) send_read(any_field());
   endtask

   initial begin
      for (int i = 0; i < MAX_COLUMNS; i++) column_level[i] = '1;
      for (int i = 0; i < LEVEL_LIMIT; i++) level_count[i] = '0;
      dep_max        = '1;
      columns_closed = '0;
      peak_seen      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_pause_until_drained();
      test_random_columns();
      test_column_capacity();

      // drain outstanding results, then watch for strays
      start <= 1'b0;
      while (result_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
